FILE: rtl/core/dtw_pkg.sv
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared widths, constants and types for the path cost block.
// ----------------------------------------------------------------------------
package dtw_pkg;
    localparam int SAMPLE_W  = 16;
    localparam int CELL_W    = 24;
    localparam int COST_W    = 32;
    localparam int SEQ_LEN_D = 32;

    // Data one cell hands to the next cell of the chain
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] a;
        logic [CELL_W-1:0]          left;
        logic [CELL_W-1:0]          diag;
        logic                       first_col;
    } dtw_link_t;

    function automatic logic [CELL_W-1:0] min3(input logic [CELL_W-1:0] x,
                                               input logic [CELL_W-1:0] y,
                                               input logic [CELL_W-1:0] z);
        logic [CELL_W-1:0] m;
        m = (x < y) ? x : y;
        return (m < z) ? m : z;
    endfunction
endpackage

FILE: rtl/core/dtw_cell.sv
// ----------------------------------------------------------------------------
// dtw_cell
// One column of the cost matrix: holds b[j] and its previous-row value.
// ----------------------------------------------------------------------------
module dtw_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load_en,
    input  logic signed [dtw_pkg::SAMPLE_W-1:0] b_in,
    input  logic                                first_cell,
    input  dtw_pkg::dtw_link_t                  link_in,
    output dtw_pkg::dtw_link_t                  link_out,
    output logic [dtw_pkg::CELL_W-1:0]          up_val
);
    import dtw_pkg::*;

    logic signed [SAMPLE_W-1:0] b_reg;
    logic [CELL_W-1:0]          up_reg;
    logic                       row0_reg;
    dtw_link_t                  out_reg;
    logic signed [SAMPLE_W:0]   diff;
    logic [CELL_W-1:0]          cost;
    logic [CELL_W-1:0]          cell_val;

    // Local cost |a-b|
    always_comb begin
        diff = {link_in.a[SAMPLE_W-1], link_in.a} - {b_reg[SAMPLE_W-1], b_reg};
        cost = diff[SAMPLE_W] ? CELL_W'(-diff) : CELL_W'(diff);
    end

    // Pick predecessor, with border cases for first row and first column
    always_comb begin
        if (row0_reg && first_cell) begin
            cell_val = cost;
        end else if (row0_reg) begin
            cell_val = cost + link_in.left;
        end else if (first_cell) begin
            cell_val = cost + up_reg;
        end else begin
            cell_val = cost + min3(link_in.diag, up_reg, link_in.left);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg      <= 1'b1;
            out_reg.valid <= 1'b0;
        end else begin
            out_reg.valid <= link_in.valid;
            if (load_en) begin
                row0_reg <= 1'b1;
            end else if (link_in.valid) begin
                row0_reg <= 1'b0;
            end
        end
        if (load_en) begin
            b_reg <= b_in;
        end
        // Advance the row wave: diag for the next cell is our old up value
        if (link_in.valid) begin
            up_reg            <= cell_val;
            out_reg.a         <= link_in.a;
            out_reg.left      <= cell_val;
            out_reg.diag      <= up_reg;
            out_reg.first_col <= 1'b0;
        end
    end

    assign link_out = out_reg;
    assign up_val   = up_reg;
endmodule

FILE: rtl/core/dtw_ram.sv
// ----------------------------------------------------------------------------
// dtw_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module dtw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/core/dtw_path_cost.sv
// ----------------------------------------------------------------------------
// dtw_path_cost
// Dynamic time warping path cost over two loaded signed sequences.
// ----------------------------------------------------------------------------
// Usage: send SEQ_LEN sample pairs on s_valid/s_ready; sample b of pair j is
// held in column cell j and sample a in a small row store. The last pair of a
// load starts the computation and closes s_ready until its path_cost item is
// taken on m_valid/m_ready, so loads run one after another.
// The fill feeds one row of a into the chain of SEQ_LEN cells each time the
// cell pointer wraps to cell 0; a row steps one cell per cycle, so exactly
// one cell finishes a matrix value each cycle and that value is written to
// the matrix RAM on the next. After the fill, ST_CORN reads the corner, and
// the backtrack reads three neighbours per step through the single RAM read
// port, in ST_RD_DG, ST_RD_UP and ST_RD_LF, before ST_PICK adds the smallest
// to the total. m_valid rises with the pick of the last backtrack step.
// The result waits in an output register while m_ready is low; s_ready
// stays low until it is taken. Reset clears the load count, the state, the
// fill counters and the output valid; the matrix RAM needs no clearing as
// every cell is written before it is read.
// ----------------------------------------------------------------------------
module dtw_path_cost #(
    parameter int SEQ_LEN = dtw_pkg::SEQ_LEN_D
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [dtw_pkg::SAMPLE_W-1:0] s_sample_a,
    input  logic signed [dtw_pkg::SAMPLE_W-1:0] s_sample_b,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dtw_pkg::COST_W-1:0]          m_path_cost
);
    import dtw_pkg::*;

    localparam int IW    = $clog2(SEQ_LEN);
    localparam int CW    = $clog2(SEQ_LEN + 1);
    localparam int DEPTH = SEQ_LEN * SEQ_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST = IW'(SEQ_LEN - 1);

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_FILL  = 7'b0000010,
        ST_CORN  = 7'b0000100,
        ST_RD_DG = 7'b0001000,
        ST_RD_UP = 7'b0010000,
        ST_RD_LF = 7'b0100000,
        ST_PICK  = 7'b1000000
    } state_t;

    state_t state_reg;
    logic [IW-1:0] load_cnt_reg;
    logic [CW-1:0] row_cnt_reg;
    logic [IW-1:0] col_cnt_reg;
    logic [IW-1:0] row_reg, col_reg;
    logic [IW-1:0] step_reg;
    logic [CELL_W-1:0] dg_reg, up_reg;
    logic [COST_W-1:0] total_reg;
    logic [COST_W-1:0] out_reg;
    logic              out_valid_reg;
    logic signed [SAMPLE_W-1:0] a_mem [SEQ_LEN];

    dtw_link_t feed;
    dtw_link_t link [SEQ_LEN+1];
    logic [CELL_W-1:0] up_vals [SEQ_LEN];

    // Position of the matrix value the chain finished in the last cycle
    logic              wr_valid_reg;
    logic [IW-1:0]     wr_row_reg, wr_col_reg;

    logic              accept;
    logic              load_en;
    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data, rd_data;
    logic [CELL_W-1:0] best;
    logic [COST_W:0]   sum;

    assign s_ready = (state_reg == ST_LOAD) && !out_valid_reg;
    assign accept  = s_valid && s_ready;
    assign load_en = accept;

    // Feed one row of a into the chain whenever the cell pointer is at cell 0 during the fill
    always_comb begin
        feed           = '0;
        feed.valid     = (state_reg == ST_FILL) && (row_cnt_reg < CW'(SEQ_LEN))
                         && (col_cnt_reg == '0);
        feed.a         = a_mem[row_cnt_reg[IW-1:0]];
        feed.first_col = 1'b1;
    end

    assign link[0] = feed;

    for (genvar j = 0; j < SEQ_LEN; j++) begin : g_cell
        dtw_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load_en    (load_en && (load_cnt_reg == IW'(j))),
            .b_in       (s_sample_b),
            .first_cell (j == 0),
            .link_in    (link[j]),
            .link_out   (link[j+1]),
            .up_val     (up_vals[j])
        );
    end

    // Track the cell that finished a value: the one the fill counters point at
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= (state_reg == ST_FILL) && (row_cnt_reg < CW'(SEQ_LEN));
        end
        wr_row_reg <= row_cnt_reg[IW-1:0];
        wr_col_reg <= col_cnt_reg;
    end

    // Write the finished value from that cell's up register
    assign wr_en   = wr_valid_reg;
    assign wr_data = up_vals[wr_col_reg];
    assign wr_addr = AW'(wr_row_reg) * AW'(SEQ_LEN) + AW'(wr_col_reg);

    assign sum = {1'b0, total_reg} + {{(COST_W-CELL_W+1){1'b0}}, best};

    dtw_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read address for the backtrack
    always_comb begin
        rd_addr = AW'(row_reg) * AW'(SEQ_LEN) + AW'(col_reg);
        case (state_reg)
            ST_CORN:  rd_addr = AW'(DEPTH - 1);
            ST_RD_DG: rd_addr = AW'(row_reg - 1'b1) * AW'(SEQ_LEN) + AW'(col_reg - 1'b1);
            ST_RD_UP: rd_addr = AW'(row_reg - 1'b1) * AW'(SEQ_LEN) + AW'(col_reg);
            ST_RD_LF: rd_addr = AW'(row_reg) * AW'(SEQ_LEN) + AW'(col_reg - 1'b1);
            default:  rd_addr = AW'(row_reg) * AW'(SEQ_LEN) + AW'(col_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_mem[load_cnt_reg] <= s_sample_a;
        end
    end

    always_comb begin
        best = min3(dg_reg, up_reg, rd_data);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
        end else begin
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        if (load_cnt_reg == LAST) begin
                            load_cnt_reg <= '0;
                            row_cnt_reg  <= '0;
                            col_cnt_reg  <= '0;
                            state_reg    <= ST_FILL;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_FILL: begin
                    // Step the cell pointer; move to the next row after the last cell
                    if (col_cnt_reg == LAST) begin
                        col_cnt_reg <= '0;
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                    end else begin
                        col_cnt_reg <= col_cnt_reg + 1'b1;
                    end
                    // Leave once the last value has been written
                    if (row_cnt_reg == CW'(SEQ_LEN)) begin
                        state_reg <= ST_CORN;
                    end
                end
                ST_CORN: begin
                    row_reg   <= LAST;
                    col_reg   <= LAST;
                    step_reg  <= '0;
                    total_reg <= '0;
                    state_reg <= ST_RD_DG;
                end
                ST_RD_DG: begin
                    if (step_reg == '0) begin
                        total_reg <= {{(COST_W-CELL_W){1'b0}}, rd_data};
                    end
                    state_reg <= ST_RD_UP;
                end
                ST_RD_UP: begin
                    dg_reg    <= rd_data;
                    state_reg <= ST_RD_LF;
                end
                ST_RD_LF: begin
                    up_reg    <= rd_data;
                    state_reg <= ST_PICK;
                end
                ST_PICK: begin
                    total_reg <= sum[COST_W] ? '1 : sum[COST_W-1:0];
                    if (best == dg_reg) begin
                        row_reg <= row_reg - 1'b1;
                        col_reg <= col_reg - 1'b1;
                    end else if (best == up_reg) begin
                        row_reg <= row_reg - 1'b1;
                    end else begin
                        col_reg <= col_reg - 1'b1;
                    end
                    if (step_reg == IW'(SEQ_LEN - 2)) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_LOAD;
                    end else begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_RD_DG;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // Hold the final value for the output item
    logic [COST_W-1:0] final_sum;
    always_comb begin
        final_sum = sum[COST_W] ? '1 : sum[COST_W-1:0];
    end
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PICK && step_reg == IW'(SEQ_LEN - 2)) begin
            out_reg <= final_sum;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_path_cost = out_reg;
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks dtw_path_cost against an in-bench path cost predictor: sample pairs
// are loaded in sets of SEQ_LEN, the predicted cost of each full set is
// queued, and every m_ items is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import dtw_pkg::*;

    localparam int  SEQ_LEN   = SEQ_LEN_D;
    localparam int  HALF      = 6;
    localparam longint LIMIT  = 2_000_000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
    } pair_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_a;
    logic signed [SAMPLE_W-1:0] s_sample_b;
    logic                       m_valid;
    logic                       m_ready;
    logic [COST_W-1:0]          m_path_cost;

    pair_t             pending_pairs[$];
    logic [COST_W-1:0] cost_queue[$];
    pair_t             cur_pair;
    logic signed [SAMPLE_W-1:0] load_a[SEQ_LEN];
    logic signed [SAMPLE_W-1:0] load_b[SEQ_LEN];
    int                loaded;
    int                send_idle_pct;
    int                recv_idle_pct;
    bit                hold_send;
    bit                s_taken;
    int                errors;
    longint            cycles;

    dtw_path_cost #(.SEQ_LEN(SEQ_LEN)) dut (.*);

    // Clock
    always begin
        aclk = 1'b1;
        #HALF;
        aclk = 1'b0;
        #HALF;
    end

    // Work out the path cost of one full load
    function automatic logic [COST_W-1:0] path_cost_of();
        logic [CELL_W-1:0] grid[SEQ_LEN][SEQ_LEN];
        logic [CELL_W-1:0] dg, up, lf, pick;
        logic [CELL_W-1:0] m;
        longint            total;
        int                r, c, d;
        for (r = 0; r < SEQ_LEN; r++) begin
            for (c = 0; c < SEQ_LEN; c++) begin
                d = int'(load_a[r]) - int'(load_b[c]);
                if (d < 0) d = -d;
                if (r == 0 && c == 0) grid[r][c] = CELL_W'(d);
                else if (r == 0) grid[r][c] = CELL_W'(d) + grid[r][c-1];
                else if (c == 0) grid[r][c] = CELL_W'(d) + grid[r-1][c];
                else begin
                    m = grid[r-1][c-1] < grid[r-1][c] ? grid[r-1][c-1] : grid[r-1][c];
                    m = m < grid[r][c-1] ? m : grid[r][c-1];
                    grid[r][c] = CELL_W'(d) + m;
                end
            end
        end
        r = SEQ_LEN - 1;
        c = SEQ_LEN - 1;
        total = longint'(grid[r][c]);
        for (int s = 0; s < SEQ_LEN - 1; s++) begin
            if (r == 0 && c == 0) pick = '0;
            else if (r == 0) begin
                c--;
                pick = grid[0][c];
            end else if (c == 0) begin
                r--;
                pick = grid[r][0];
            end else begin
                dg = grid[r-1][c-1];
                up = grid[r-1][c];
                lf = grid[r][c-1];
                pick = dg < up ? dg : up;
                pick = pick < lf ? pick : lf;
                if (pick == dg) begin
                    r--;
                    c--;
                end else if (pick == up) r--;
                else c--;
            end
            total += longint'(pick);
            if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        end
        return total[COST_W-1:0];
    endfunction

    // Queue one load of pairs from a fill style
    task automatic queue_load(input int style);
        pair_t p;
        for (int k = 0; k < SEQ_LEN; k++) begin
            case (style)
                0: begin p.a = 16'sh7FFF; p.b = 16'sh8000; end
                1: begin p.a = 16'sh8000; p.b = 16'sh7FFF; end
                2: begin p.a = 16'sd5;    p.b = 16'sd5;    end
                3: begin
                    p.a = k[0] ? 16'sh7FFF : 16'sh8000;
                    p.b = k[1] ? 16'sh7FFF : 16'sh8000;
                end
                4: begin
                    p.a = SAMPLE_W'($urandom_range(0, 7));
                    p.b = SAMPLE_W'($urandom_range(0, 7));
                end
                default: begin p.a = SAMPLE_W'($urandom); p.b = SAMPLE_W'($urandom); end
            endcase
            pending_pairs.push_back(p);
        end
    endtask

    // Driver: present the next pair at the falling edge once the last is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_pairs.size() > 0 && !hold_send
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_pair = pending_pairs.pop_front();
                s_sample_a <= cur_pair.a;
                s_sample_b <= cur_pair.b;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: predict on accepted pairs, check accepted results
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                load_a[loaded] = s_sample_a;
                load_b[loaded] = s_sample_b;
                if (loaded == SEQ_LEN - 1) begin
                    cost_queue.push_back(path_cost_of());
                    loaded = 0;
                end else begin
                    loaded = loaded + 1;
                end
            end
            if (m_valid && m_ready) begin
                if (cost_queue.size() == 0) begin
                    $error("path_cost with no result expected: got %0d", m_path_cost);
                    errors++;
                end else if (cost_queue[0] !== m_path_cost) begin
                    $error("path_cost: expected %0d, actual %0d",
                           cost_queue[0], m_path_cost);
                    errors++;
                    void'(cost_queue.pop_front());
                end else begin
                    void'(cost_queue.pop_front());
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Wait until the driver has drained and every cost has arrived
    task automatic drain();
        while (pending_pairs.size() > 0 || s_valid || cost_queue.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_sample_a = '0;
        s_sample_b = '0;
        hold_send = 1'b0;
        s_taken = 1'b0;
        loaded = 0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed loads: extremes, all equal, alternating signs, small ties
        for (int s = 0; s < 5; s++) queue_load(s);
        drain();

        // Random loads under three idling mixes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 80 : 0;
            recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 30 : 0;
            for (int n = 0; n < 21; n++) begin
                queue_load(($urandom_range(0, 3) == 0) ? 4 : 5);
                if (n == 10) begin
                    // wait until all costs have come back, then hold the sender for a random pause
                    drain();
                    hold_send = 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                    hold_send = 1'b0;
                end
            end
            drain();
        end

        repeat (8 * SEQ_LEN) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
